// ----- rtl/core/ffs_pkg.sv -----
// Shared types, constants and register codes of the flight failsafe supervisor.
`default_nettype none

package ffs_pkg;

    // Widths of time stamps and of the ground-detect counter.
    localparam int TIME_BITS  = 32;
    localparam int COUNT_BITS = 16;

    // Stream payload widths, padded to whole bytes.
    localparam int IN_BITS   = 83;
    localparam int IN_BYTES  = (IN_BITS + 7) / 8;
    localparam int OUT_BITS  = 6;
    localparam int OUT_BYTES = (OUT_BITS + 7) / 8;

    // Configuration register indexes.
    localparam int CFG_IDX_BITS = 3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LINK_TIMEOUT = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LONG_LOSS    = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_STILL_SPEED  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_STILL_TICKS  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_INVERTED     = 3'd4;

    // Requested power codes carried by a pilot message.
    localparam logic [1:0] PWR_NONE = 2'd0;
    localparam logic [1:0] PWR_ON   = 2'd1;
    localparam logic [1:0] PWR_OFF  = 2'd2;

    // Ground-detect constants: descent target and counter decay.
    localparam logic signed [15:0]   DESCEND_TARGET = -16'sd10;
    localparam logic [COUNT_BITS-1:0] COUNT_DROP    = COUNT_BITS'(9);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX     = '1;

    // Flight modes.
    typedef enum logic [1:0] {
        MODE_OFF  = 2'd0,
        MODE_USER = 2'd1,
        MODE_DISC = 2'd2,
        MODE_LONG = 2'd3
    } t_mode;

    // Configuration register set.
    typedef struct packed {
        logic [TIME_BITS-1:0]  link_timeout_us;
        logic [TIME_BITS-1:0]  long_loss_us;
        logic [14:0]           still_speed_limit;
        logic [COUNT_BITS-1:0] still_ticks_needed;
        logic signed [15:0]    inverted_limit;
    } t_cfg;

    // One control tick.
    typedef struct packed {
        logic [TIME_BITS-1:0] now_us;
        logic                 msg_valid;
        logic [1:0]           msg_power;
        logic signed [15:0]   climb_speed;
        logic signed [15:0]   climb_target;
        logic signed [15:0]   accel_vertical;
    } t_in_item;

    // Supervisor state carried from tick to tick.
    typedef struct packed {
        t_mode                 mode;
        logic                  power;
        logic                  link;
        logic [TIME_BITS-1:0]  last_msg_time;
        logic [TIME_BITS-1:0]  loss_time;
        logic [COUNT_BITS-1:0] still_count;
    } t_state;

    // One result item.
    typedef struct packed {
        logic       motors_on;
        logic       reply_now;
        logic       link_up;
        logic       power_cmd;
        logic [1:0] flight_mode;
    } t_result;

endpackage

`default_nettype wire

// ----- rtl/core/ffs_cfg.sv -----
// Configuration register file of the flight failsafe supervisor.
`default_nettype none

module ffs_cfg
    import ffs_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_valid,
    input  wire logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  wire logic [31:0]             i_cfg_data,
    output t_cfg                         o_cfg
);

    t_cfg r_cfg;

    // Writes to indexes outside the register list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.link_timeout_us    <= TIME_BITS'(500000);
            r_cfg.long_loss_us       <= TIME_BITS'(5000000);
            r_cfg.still_speed_limit  <= 15'd10;
            r_cfg.still_ticks_needed <= COUNT_BITS'(100);
            r_cfg.inverted_limit     <= -16'sd4096;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_LINK_TIMEOUT: r_cfg.link_timeout_us    <= i_cfg_data[TIME_BITS-1:0];
                CFG_LONG_LOSS:    r_cfg.long_loss_us       <= i_cfg_data[TIME_BITS-1:0];
                CFG_STILL_SPEED:  r_cfg.still_speed_limit  <= i_cfg_data[14:0];
                CFG_STILL_TICKS:  r_cfg.still_ticks_needed <= i_cfg_data[COUNT_BITS-1:0];
                CFG_INVERTED:     r_cfg.inverted_limit     <= signed'(i_cfg_data[15:0]);
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ----- rtl/core/ffs_step.sv -----
// Per-tick next-state logic: link judgment, mode machine, ground detect, upside-down override.
`default_nettype none

module ffs_step
    import ffs_pkg::*;
(
    input  wire t_cfg     i_cfg,
    input  wire t_state   i_state,
    input  wire t_in_item i_item,
    output t_state        o_state,
    output t_result       o_res
);

    logic [TIME_BITS-1:0]  last1;
    logic [TIME_BITS-1:0]  loss2;
    logic [TIME_BITS-1:0]  gap;
    logic [TIME_BITS-1:0]  lost_for;
    logic                  link1;
    logic                  link2;
    logic                  pow1;
    logic                  long_expired;
    logic [16:0]           speed_mag;
    logic                  qualify;
    logic [COUNT_BITS-1:0] cnt_step;
    logic                  landed;
    t_mode                 mode_mid;
    logic                  clear_cnt;
    logic                  use_step;
    logic                  land;
    logic                  inverted;
    t_mode                 mode_out;

    // Message refresh, then link timeout against the refreshed stamp.
    always_comb begin
        last1 = i_state.last_msg_time;
        link1 = i_state.link;
        pow1  = i_state.power;
        if (i_item.msg_valid) begin
            last1 = i_item.now_us;
            link1 = 1'b1;
            if (i_item.msg_power == PWR_ON) begin
                pow1 = 1'b1;
            end else if (i_item.msg_power == PWR_OFF) begin
                pow1 = 1'b0;
            end
        end
        gap   = i_item.now_us - last1;
        link2 = link1;
        loss2 = i_state.loss_time;
        if (link1 && (gap > i_cfg.link_timeout_us)) begin
            link2 = 1'b0;
            loss2 = i_item.now_us;
        end
        lost_for = i_item.now_us - loss2;
    end

    assign long_expired = lost_for > i_cfg.long_loss_us;

    // Ground counter step: count up on a still, descending tick, else decay.
    assign speed_mag = i_item.climb_speed[15]
                     ? 17'(-{i_item.climb_speed[15], i_item.climb_speed})
                     : {1'b0, i_item.climb_speed};
    assign qualify = (i_item.climb_target <= DESCEND_TARGET)
                  && (speed_mag < {2'b00, i_cfg.still_speed_limit});

    always_comb begin
        if (qualify) begin
            cnt_step = (i_state.still_count == COUNT_MAX)
                     ? i_state.still_count : i_state.still_count + COUNT_BITS'(1);
        end else begin
            cnt_step = (i_state.still_count > COUNT_DROP)
                     ? i_state.still_count - COUNT_DROP : '0;
        end
    end

    assign landed = cnt_step >= i_cfg.still_ticks_needed;

    // Mode machine next state.
    always_comb begin
        mode_mid  = i_state.mode;
        clear_cnt = 1'b0;
        use_step  = 1'b0;
        land      = 1'b0;
        unique case (i_state.mode)
            MODE_OFF: begin
                if (link2 && pow1) begin
                    mode_mid = MODE_USER;
                end
            end
            MODE_USER: begin
                if (link2) begin
                    if (!pow1) begin
                        mode_mid = MODE_OFF;
                    end
                end else if (!long_expired) begin
                    mode_mid = MODE_DISC;
                end else begin
                    mode_mid  = MODE_LONG;
                    clear_cnt = 1'b1;
                end
            end
            MODE_DISC: begin
                if (link2) begin
                    mode_mid = pow1 ? MODE_USER : MODE_OFF;
                end else if (long_expired) begin
                    mode_mid  = MODE_LONG;
                    clear_cnt = 1'b1;
                end
            end
            MODE_LONG: begin
                if (link2) begin
                    mode_mid = pow1 ? MODE_USER : MODE_OFF;
                end else begin
                    use_step = 1'b1;
                    if (landed) begin
                        land     = 1'b1;
                        mode_mid = MODE_OFF;
                    end
                end
            end
        endcase
    end

    // Upside-down override and the state and result outputs.
    assign inverted = i_item.accel_vertical <= i_cfg.inverted_limit;
    assign mode_out = inverted ? MODE_OFF : mode_mid;

    always_comb begin
        o_state.mode          = mode_out;
        o_state.power         = (inverted || land) ? 1'b0 : pow1;
        o_state.link          = link2;
        o_state.last_msg_time = last1;
        o_state.loss_time     = loss2;
        if (clear_cnt) begin
            o_state.still_count = '0;
        end else if (use_step) begin
            o_state.still_count = cnt_step;
        end else begin
            o_state.still_count = i_state.still_count;
        end

        o_res.flight_mode = mode_out;
        o_res.power_cmd   = o_state.power;
        o_res.link_up     = link2;
        o_res.reply_now   = i_item.msg_valid;
        o_res.motors_on   = mode_out != MODE_OFF;
    end

endmodule

`default_nettype wire

// ----- rtl/core/flight_failsafe_supervisor.sv -----
// Top level of the flight failsafe supervisor: input register, state, result register.
//
// Usage: one control tick enters per item on the slave stream (s_axis), and
// one result item leaves per tick on the master stream (m_axis), in order.
// Configuration registers are written on a separate valid/ready channel
// (index 0..4, ready always high); write them only while no tick is in flight.
// Path: an accepted item is held in the input register, passes the link
// compare, mode machine and ground-counter step into the result register
// once that register is free, and is then offered on the master stream.
// Throughput: one item per cycle while the receiver does not stall; the
// per-tick logic between the two registers is combinational.
// Reset (synchronous, active low) empties both registers, puts the mode and
// power off, the link down, time stamps and the counter at zero, and loads
// the register defaults.
// When the receiver stalls, the result register holds its item, the input
// register fills, and o_s_tready drops until the result is taken.
`default_nettype none

module flight_failsafe_supervisor
    import ffs_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    // Tick stream. tdata from bit 0: now_us[31:0], msg_valid[32],
    // msg_power[34:33], climb_speed[50:35], climb_target[66:51],
    // accel_vertical[82:67], zero pad [87:83].
    input  wire logic                    i_s_tvalid,
    output logic                         o_s_tready,
    input  wire logic [IN_BYTES*8-1:0]   i_s_tdata,
    // Result stream. tdata from bit 0: flight_mode[1:0], power_cmd[2],
    // link_up[3], reply_now[4], motors_on[5], zero pad [7:6].
    output logic                         o_m_tvalid,
    input  wire logic                    i_m_tready,
    output logic [OUT_BYTES*8-1:0]       o_m_tdata,
    // Configuration write channel.
    input  wire logic                    i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  wire logic [31:0]             i_cfg_data
);

    t_cfg     cfg;
    t_in_item in_item;
    t_state   n_state;
    t_result  n_res;
    logic     in_take;
    logic     move;

    logic     r_in_vld;
    t_in_item r_in;
    t_state   r_state;
    logic     r_out_vld;
    t_result  r_out;

    // Configuration registers.
    assign o_cfg_ready = 1'b1;

    ffs_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // Unpack the incoming item.
    assign in_item.now_us         = i_s_tdata[31:0];
    assign in_item.msg_valid      = i_s_tdata[32];
    assign in_item.msg_power      = i_s_tdata[34:33];
    assign in_item.climb_speed    = signed'(i_s_tdata[50:35]);
    assign in_item.climb_target   = signed'(i_s_tdata[66:51]);
    assign in_item.accel_vertical = signed'(i_s_tdata[82:67]);

    // An item moves from the input register to the result register whenever
    // the result register is free or being emptied this cycle.
    assign move       = r_in_vld && (!r_out_vld || i_m_tready);
    assign o_s_tready = !r_in_vld || move;
    assign in_take    = i_s_tvalid && o_s_tready;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_s_tready) begin
            r_in_vld <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= in_item;
        end
    end

    // Per-tick logic.
    ffs_step u_step (
        .i_cfg   (cfg),
        .i_state (r_state),
        .i_item  (r_in),
        .o_state (n_state),
        .o_res   (n_res)
    );

    // Supervisor state advances once per item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode          <= MODE_OFF;
            r_state.power         <= 1'b0;
            r_state.link          <= 1'b0;
            r_state.last_msg_time <= '0;
            r_state.loss_time     <= '0;
            r_state.still_count   <= '0;
        end else if (move) begin
            r_state <= n_state;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (move) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_out <= n_res;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {{(OUT_BYTES*8-OUT_BITS){1'b0}}, r_out};

endmodule

`default_nettype wire

// ----- rtl/core/ffs_chk.sv -----
// Port-level checker of the flight failsafe supervisor and its bind.
`default_nettype none

module ffs_chk
    import ffs_pkg::*;
(
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   o_m_tvalid,
    input wire logic                   i_m_tready,
    input wire logic [OUT_BYTES*8-1:0] o_m_tdata
);

    // A result that is not taken stays and does not change.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result item changed while stalled");

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

    // Motors run exactly when the mode is not off.
    a_motors: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[5] == (o_m_tdata[1:0] != MODE_OFF)))
        else $error("motors_on disagrees with flight_mode");

    // A message tick always leaves the link up.
    a_reply_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[4] |-> o_m_tdata[3])
        else $error("link down on a tick with a message");

    // User mode is held only with the link up and power commanded on.
    a_user_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tdata[1:0] == MODE_USER) |-> o_m_tdata[3] && o_m_tdata[2])
        else $error("user mode without link or power");

endmodule

bind flight_failsafe_supervisor ffs_chk u_ffs_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

`default_nettype wire
